### hw/rtl/string_to_int64_parser_macros.svh
// assertion macros shared by the string to integer parser rtl
// expects clk and rst_n in the scope of the module that uses them
`ifndef STRING_TO_INT64_PARSER_MACROS_SVH
`define STRING_TO_INT64_PARSER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define S2I_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define S2I_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/s2i_pkg.sv
// shared types, constants and character helpers for the string to integer parser
// no dependencies
package s2i_pkg;

    // defaults for the top level parameters
    localparam int MAX_BASE_DEF    = 36;
    localparam int OFFSET_BITS_DEF = 16;

    // fixed field widths
    localparam int CH_W    = 8;
    localparam int BASE_W  = 6;
    localparam int VALUE_W = 64;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = BASE_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE        = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE = 1'd1;

    // register reset values and fixed bases
    localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
    localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
    localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;

    // digit code for a character that is no digit in any base
    localparam logic [BASE_W-1:0] DIGIT_NONE = 6'd63;

    // characters with a meaning of their own
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_LOW_X = 8'h78;
    localparam logic [CH_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;

    // saturation patterns
    localparam logic [VALUE_W-1:0] VAL_SMAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] VAL_SMIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic [VALUE_W-1:0] VAL_UMAX = {VALUE_W{1'b1}};

    // range selection for the overflow check
    typedef struct packed {
        logic signed_mode;
        logic negative;
    } s2i_range_t;

    // digit value of a character, letters count from ten
    function automatic logic [BASE_W-1:0] digit_of(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] t;
        begin
            t = {CH_W{1'b0}};
            if (c >= 8'h30 && c <= 8'h39)
            begin
                t = c - 8'h30;
                return t[BASE_W-1:0];
            end
            if (c >= 8'h61 && c <= 8'h7A)
            begin
                t = c - 8'h57;
                return t[BASE_W-1:0];
            end
            if (c >= 8'h41 && c <= 8'h5A)
            begin
                t = c - 8'h37;
                return t[BASE_W-1:0];
            end
            return DIGIT_NONE;
        end
    endfunction

    // space, tab, line feed, vertical tab, form feed, carriage return
    function automatic logic is_space(input logic [CH_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

### hw/rtl/s2i_ifs.sv
// valid/ready channel interfaces for the string to integer parser
// depends on s2i_pkg
interface s2i_char_if;
    import s2i_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            start_req;

    modport source (output valid, output ch, output start_req, input ready);
    modport sink   (input valid, input ch, input start_req, output ready);
endinterface

interface s2i_result_if #(
    parameter int OFFSET_BITS = s2i_pkg::OFFSET_BITS_DEF
);
    import s2i_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [VALUE_W-1:0]     value;
    logic                   overflow;
    logic                   digits_found;
    logic [OFFSET_BITS-1:0] end_offset;

    modport source (output valid, output value, output overflow, output digits_found,
                    output end_offset, input ready);
    modport sink   (input valid, input value, input overflow, input digits_found,
                    input end_offset, output ready);
endinterface

### hw/rtl/s2i_mac.sv
// digit multiply-accumulate with range check against the signed or unsigned limit
// depends on s2i_pkg
module s2i_mac (
    input  logic [s2i_pkg::VALUE_W-1:0] acc,
    input  logic [s2i_pkg::BASE_W-1:0]  radix,
    input  logic [s2i_pkg::BASE_W-1:0]  digit,
    input  s2i_pkg::s2i_range_t         range,
    output logic [s2i_pkg::VALUE_W-1:0] acc_sum,
    output logic                        over
);
    import s2i_pkg::*;

    localparam int SUM_W = VALUE_W + BASE_W + 1;

    logic [VALUE_W-1:0] limit;
    logic [SUM_W-1:0]   sum_w;

    // largest magnitude allowed for the current sign and mode
    always_comb
    begin
        if (range.signed_mode)
            limit = range.negative ? VAL_SMIN : VAL_SMAX;
        else
            limit = VAL_UMAX;
    end

    // over flags acc * radix + digit above the limit, compared at full width
    assign sum_w   = SUM_W'(acc) * SUM_W'(radix) + SUM_W'(digit);
    assign over    = sum_w > SUM_W'(limit);
    assign acc_sum = sum_w[VALUE_W-1:0];

endmodule

### hw/rtl/string_to_int64_parser.sv
// string to 64-bit integer parser top level: config registers, parse state, result register
// depends on s2i_pkg, s2i_ifs, s2i_mac and string_to_int64_parser_macros.svh
//
//  port     | dir  | carries
//  ---------+------+-------------------------------------------------------
//  chars    | sink | ch, start_req: one character per item
//  result   | src  | value, overflow, digits_found, end_offset
//  cfg_*    | in   | register write: enable, index, data (no read-back)
//
// one character per cycle unless stalled: the digit multiply-accumulate and limit compare
// loop is combinational, a result appears the cycle after its last character
// a held result stalls the input only when the sink is not ready in the same cycle
// reset puts the parser idle with base 10 and signed mode
// characters arriving while idle without start_req are dropped
module string_to_int64_parser #(
    parameter int MAX_BASE    = s2i_pkg::MAX_BASE_DEF,
    parameter int OFFSET_BITS = s2i_pkg::OFFSET_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    s2i_char_if.sink                       chars,
    s2i_result_if.source                   result,
    input  logic                           cfg_wr_en,
    input  logic [s2i_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [s2i_pkg::CFG_DATA_W-1:0] cfg_data
);
    import s2i_pkg::*;

    `include "string_to_int64_parser_macros.svh"

    localparam int CNT_W = OFFSET_BITS + 1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_SIGN,
        PH_ZERO,
        PH_XPFX,
        PH_DIGS
    } phase_t;

    // configuration
    logic [BASE_W-1:0] base_reg;
    logic              signed_mode_reg;

    // parse state
    phase_t             phase_reg, phase_next;
    logic               negative_reg, negative_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [BASE_W-1:0]  eff_base_reg, eff_base_next;
    logic               any_digit_reg, any_digit_next;
    logic               ovf_reg, ovf_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    // result register
    logic                   res_valid_reg;
    logic [VALUE_W-1:0]     res_value_reg, res_value_next;
    logic                   res_ovf_reg;
    logic                   res_digits_reg;
    logic [OFFSET_BITS-1:0] res_end_reg, res_end_next;

    // state after a start request is applied
    phase_t             phase_s;
    logic               negative_s;
    logic [VALUE_W-1:0] acc_s;
    logic [BASE_W-1:0]  eff_base_s;
    logic               any_digit_s;
    logic               ovf_s;
    logic [CNT_W-1:0]   cnt_s;

    logic                   accept;
    logic                   emit;
    logic                   take;
    logic                   sign_path;
    logic                   take_ok;
    logic [BASE_W-1:0]      digit;
    logic [BASE_W-1:0]      take_base;
    logic [OFFSET_BITS-1:0] cur_off;
    logic [OFFSET_BITS-1:0] x_off;
    logic [OFFSET_BITS-1:0] emit_end;
    logic [CNT_W-1:0]       cnt_dec;
    logic [VALUE_W-1:0]     mac_sum;
    logic                   mac_over;
    s2i_range_t             range;

    // handshake: the result register frees up in the cycle it is taken
    assign chars.ready = !res_valid_reg || result.ready;
    assign accept      = chars.valid && chars.ready;

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg        <= BASE_RESET;
            signed_mode_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_BASE:        base_reg        <= cfg_data;
                CFG_SIGNED_MODE: signed_mode_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // a start request clears the conversion before the character is looked at
    assign phase_s     = chars.start_req ? PH_LEAD : phase_reg;
    assign negative_s  = chars.start_req ? 1'b0 : negative_reg;
    assign acc_s       = chars.start_req ? '0 : acc_reg;
    assign eff_base_s  = chars.start_req ? BASE_DEC : eff_base_reg;
    assign any_digit_s = chars.start_req ? 1'b0 : any_digit_reg;
    assign ovf_s       = chars.start_req ? 1'b0 : ovf_reg;
    assign cnt_s       = chars.start_req ? '0 : cnt_reg;

    // offsets of this character and of the one before, saturating
    assign cur_off = cnt_s[OFFSET_BITS] ? {OFFSET_BITS{1'b1}} : cnt_s[OFFSET_BITS-1:0];
    assign cnt_dec = cnt_s - CNT_W'(1);
    assign x_off   = cnt_dec[OFFSET_BITS-1:0];

    // base used if this character is taken as a digit
    assign digit     = digit_of(chars.ch);
    assign take_base = (phase_s == PH_LEAD || phase_s == PH_SIGN)
                     ? ((base_reg == BASE_AUTO) ? BASE_DEC : base_reg)
                     : eff_base_s;
    assign take_ok   = (take_base >= BASE_MIN) && (take_base <= BASE_W'(MAX_BASE))
                     && (digit < take_base);

    // a digit never arrives together with a sign, so the stored sign sets the limit
    assign range.signed_mode = signed_mode_reg;
    assign range.negative    = negative_s;

    s2i_mac u_mac (
        .acc     (acc_s),
        .radix   (take_base),
        .digit   (digit),
        .range   (range),
        .acc_sum (mac_sum),
        .over    (mac_over)
    );

    // per-character phase logic
    always_comb
    begin
        phase_next     = phase_s;
        negative_next  = negative_s;
        acc_next       = acc_s;
        eff_base_next  = eff_base_s;
        any_digit_next = any_digit_s;
        ovf_next       = ovf_s;
        cnt_next       = cnt_s;
        sign_path      = 1'b0;
        take           = 1'b0;
        emit           = 1'b0;
        emit_end       = cur_off;

        if (phase_s != PH_IDLE && !cnt_s[OFFSET_BITS])
            cnt_next = cnt_s + CNT_W'(1);

        case (phase_s)
            PH_IDLE: ;
            PH_LEAD:
            begin
                if (is_space(chars.ch))
                    phase_next = PH_LEAD;
                else if (chars.ch == CH_MINUS)
                begin
                    negative_next = 1'b1;
                    phase_next    = PH_SIGN;
                end
                else if (chars.ch == CH_PLUS)
                    phase_next = PH_SIGN;
                else
                    sign_path = 1'b1;
            end
            PH_SIGN: sign_path = 1'b1;
            PH_ZERO:
            begin
                if (chars.ch == CH_LOW_X || chars.ch == CH_UP_X)
                begin
                    eff_base_next = BASE_HEX;
                    phase_next    = PH_XPFX;
                end
                else
                    take = 1'b1;
            end
            PH_XPFX:
            begin
                if (digit < BASE_HEX)
                    take = 1'b1;
                else
                begin
                    emit     = 1'b1;
                    emit_end = x_off;
                end
            end
            PH_DIGS: take = 1'b1;
            default: phase_next = PH_IDLE;
        endcase

        // first character after whitespace and sign: leading zero or plain digit
        if (sign_path)
        begin
            if (chars.ch == CH_ZERO && (base_reg == BASE_AUTO || base_reg == BASE_HEX))
            begin
                any_digit_next = 1'b1;
                eff_base_next  = (base_reg == BASE_HEX) ? BASE_HEX : BASE_OCT;
                phase_next     = PH_ZERO;
            end
            else
            begin
                eff_base_next = take_base;
                take          = 1'b1;
            end
        end

        // digit accumulate, or the end of the number
        if (take)
        begin
            phase_next = PH_DIGS;
            if (!take_ok)
                emit = 1'b1;
            else
            begin
                any_digit_next = 1'b1;
                if (!ovf_s)
                begin
                    if (mac_over)
                        ovf_next = 1'b1;
                    else
                        acc_next = mac_sum;
                end
            end
        end

        if (emit)
            phase_next = PH_IDLE;
    end

    // result pattern for an ending character
    always_comb
    begin
        if (ovf_next)
        begin
            if (signed_mode_reg)
                res_value_next = negative_next ? VAL_SMIN : VAL_SMAX;
            else
                res_value_next = VAL_UMAX;
        end
        else
            res_value_next = negative_next ? (VALUE_W'(0) - acc_next) : acc_next;
        res_end_next = any_digit_next ? emit_end : '0;
    end

    // parse state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            negative_reg   <= 1'b0;
            acc_reg        <= '0;
            eff_base_reg   <= BASE_DEC;
            any_digit_reg  <= 1'b0;
            ovf_reg        <= 1'b0;
            cnt_reg        <= '0;
            res_valid_reg  <= 1'b0;
            res_value_reg  <= '0;
            res_ovf_reg    <= 1'b0;
            res_digits_reg <= 1'b0;
            res_end_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                negative_reg  <= negative_next;
                acc_reg       <= acc_next;
                eff_base_reg  <= eff_base_next;
                any_digit_reg <= any_digit_next;
                ovf_reg       <= ovf_next;
                cnt_reg       <= cnt_next;
            end
            if (accept && emit)
            begin
                res_valid_reg  <= 1'b1;
                res_value_reg  <= res_value_next;
                res_ovf_reg    <= ovf_next;
                res_digits_reg <= any_digit_next;
                res_end_reg    <= res_end_next;
            end
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.value        = res_value_reg;
    assign result.overflow     = res_ovf_reg;
    assign result.digits_found = res_digits_reg;
    assign result.end_offset   = res_end_reg;

    // checks on the parse logic
    `S2I_ASSERT_SAME(a_no_digit_result, result.valid && !result.digits_found,
        result.value == '0 && result.end_offset == '0 && !result.overflow,
        "result without digits is not all zero")
    `S2I_ASSERT_SAME(a_ovf_needs_digit, result.valid && result.overflow,
        result.digits_found, "overflow reported without a digit")
    `S2I_ASSERT_NEXT(a_emit_goes_idle, accept && emit,
        phase_reg == PH_IDLE && res_valid_reg, "ending item did not close the conversion")
    `S2I_ASSERT_NEXT(a_start_runs, accept && chars.start_req,
        phase_reg != PH_IDLE || res_valid_reg, "start item neither ran nor ended")

endmodule

### tb/tb_string_to_int64_parser.sv
`timescale 1ns / 100ps
// self-checking testbench for string_to_int64_parser: directed and random character streams
// depends on s2i_pkg, s2i_ifs and the string_to_int64_parser top level
module tb_string_to_int64_parser;
    import s2i_pkg::*;

    // characters used by the stimulus and the predictor
    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_LOW_A = 8'h61;
    localparam logic [CH_W-1:0] CH_LOW_Z = 8'h7A;
    localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CH_W-1:0] CH_UP_Z  = 8'h5A;

    localparam int OFF_W = OFFSET_BITS_DEF;
    localparam logic [OFF_W:0] OFF_MAX = (OFF_W+1)'((1 << OFF_W) - 1);
    localparam int RAND_CHARS = 800;
    localparam int N_SET = 12;

    typedef enum logic [2:0] {
        PS_IDLE, PS_LEAD, PS_SIGN, PS_ZERO, PS_XPFX, PS_DIGS
    } parse_phase_t;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            start_req;
    } char_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               overflow;
        logic               digits_found;
        logic [OFF_W-1:0]   end_offset;
    } conv_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    s2i_char_if   chars_if ();
    s2i_result_if result_if ();

    string_to_int64_parser i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars_if),
        .result    (result_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // stimulus and scoreboard state
    char_item_t   pending_chars [$];
    conv_result_t conv_expected [$];
    int           chars_queued = 0;
    int           chars_accepted = 0;
    int           error_count = 0;
    int           src_idle_pct = 19;
    int           sink_idle_pct = 69;
    bit           char_taken = 1'b0;
    bit           next_start = 1'b0;
    logic [BASE_W-1:0] gen_base = BASE_RESET;

    // predictor copy of the registers and parse state
    logic [BASE_W-1:0]  cfg_base = BASE_RESET;
    logic               cfg_signed = 1'b1;
    parse_phase_t       ps = PS_IDLE;
    logic               neg = 1'b0;
    logic [VALUE_W-1:0] acc = '0;
    logic [BASE_W-1:0]  eff_base = BASE_DEC;
    logic               seen_digit = 1'b0;
    logic               sat = 1'b0;
    logic [OFF_W:0]     pos = '0;

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [BASE_W-1:0] char_digit(input logic [CH_W-1:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return BASE_W'(c - CH_ZERO);
        if (c >= CH_LOW_A && c <= CH_LOW_Z)
            return BASE_W'(c - CH_LOW_A + 8'd10);
        if (c >= CH_UP_A && c <= CH_UP_Z)
            return BASE_W'(c - CH_UP_A + 8'd10);
        return DIGIT_NONE;
    endfunction

    function automatic logic is_blank(input logic [CH_W-1:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [CH_W-1:0] digit_char(input logic [BASE_W-1:0] d);
        if (d < 10)
            return CH_ZERO + CH_W'(d);
        return ($urandom_range(1) ? CH_LOW_A : CH_UP_A) + CH_W'(d) - 8'd10;
    endfunction

    // close the conversion and form its result
    function automatic void finish_conv(input logic [OFF_W-1:0] end_pos, output bit got,
                                        output conv_result_t r);
        if (sat)
            r.value = cfg_signed ? (neg ? VAL_SMIN : VAL_SMAX) : VAL_UMAX;
        else
            r.value = neg ? (64'd0 - acc) : acc;
        r.overflow     = sat;
        r.digits_found = seen_digit;
        r.end_offset   = seen_digit ? end_pos : '0;
        ps  = PS_IDLE;
        got = 1'b1;
    endfunction

    // one character against the effective base, with overflow saturation
    function automatic void accept_digit(input logic [CH_W-1:0] c, input logic [OFF_W-1:0] cur,
                                         output bit got, output conv_result_t r);
        logic [BASE_W-1:0]  d;
        logic [VALUE_W-1:0] b;
        logic [VALUE_W-1:0] ceiling;
        logic [VALUE_W-1:0] cutoff;
        logic [VALUE_W-1:0] cutlim;
        got = 1'b0;
        r = '0;
        d = char_digit(c);
        if (eff_base < BASE_MIN || eff_base > MAX_BASE_DEF || d >= eff_base)
        begin
            finish_conv(cur, got, r);
            return;
        end
        seen_digit = 1'b1;
        if (sat)
            return;
        b = VALUE_W'(eff_base);
        ceiling = cfg_signed ? (neg ? VAL_SMIN : VAL_SMAX) : VAL_UMAX;
        cutoff = ceiling / b;
        cutlim = ceiling % b;
        if (acc > cutoff || (acc == cutoff && VALUE_W'(d) > cutlim))
            sat = 1'b1;
        else
            acc = acc * b + VALUE_W'(d);
    endfunction

    // advance the parse by one accepted item
    function automatic void convert_char(input logic [CH_W-1:0] c, input logic st,
                                         output bit got, output conv_result_t r);
        logic [OFF_W:0]   idx;
        logic [OFF_W:0]   xpos;
        logic [OFF_W-1:0] cur;
        got = 1'b0;
        r = '0;
        if (st)
        begin
            ps = PS_LEAD;
            neg = 1'b0;
            acc = '0;
            eff_base = BASE_DEC;
            seen_digit = 1'b0;
            sat = 1'b0;
            pos = '0;
        end
        if (ps == PS_IDLE)
            return;
        idx = pos;
        if (pos <= OFF_MAX)
            pos = pos + 1'b1;
        cur = (idx > OFF_MAX) ? OFF_MAX[OFF_W-1:0] : idx[OFF_W-1:0];

        // blanks and one sign before anything else
        if (ps == PS_LEAD)
        begin
            if (is_blank(c))
                return;
            if (c == CH_MINUS)
            begin
                neg = 1'b1;
                ps = PS_SIGN;
                return;
            end
            if (c == CH_PLUS)
            begin
                ps = PS_SIGN;
                return;
            end
            ps = PS_SIGN;
        end

        case (ps)
            PS_SIGN:
            begin
                if (c == CH_ZERO && (cfg_base == BASE_AUTO || cfg_base == BASE_HEX))
                begin
                    seen_digit = 1'b1;
                    eff_base = (cfg_base == BASE_HEX) ? BASE_HEX : BASE_OCT;
                    ps = PS_ZERO;
                end
                else
                begin
                    eff_base = (cfg_base == BASE_AUTO) ? BASE_DEC : cfg_base;
                    ps = PS_DIGS;
                    accept_digit(c, cur, got, r);
                end
            end
            PS_ZERO:
            begin
                if (c == CH_LOW_X || c == CH_UP_X)
                begin
                    eff_base = BASE_HEX;
                    ps = PS_XPFX;
                end
                else
                begin
                    ps = PS_DIGS;
                    accept_digit(c, cur, got, r);
                end
            end
            PS_XPFX:
            begin
                if (char_digit(c) < BASE_HEX)
                begin
                    ps = PS_DIGS;
                    accept_digit(c, cur, got, r);
                end
                else
                begin
                    // prefix with no hex digit: only the zero counts
                    xpos = idx - 1'b1;
                    finish_conv((xpos > OFF_MAX) ? OFF_MAX[OFF_W-1:0] : xpos[OFF_W-1:0],
                                got, r);
                end
            end
            PS_DIGS:
                accept_digit(c, cur, got, r);
            default:
                ps = PS_IDLE;
        endcase
    endfunction

    task automatic report_error(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        error_count++;
    endtask

    // prediction on accepted items, checking of accepted results
    always @(posedge clk)
    begin
        bit           produced;
        conv_result_t fresh;
        conv_result_t want;
        if (rst_n)
        begin
            char_taken <= chars_if.valid && chars_if.ready;
            if (cfg_wr_en)
            begin
                if (cfg_index == CFG_BASE)
                    cfg_base = cfg_data;
                else if (cfg_index == CFG_SIGNED_MODE)
                    cfg_signed = cfg_data[0];
            end
            if (chars_if.valid && chars_if.ready)
            begin
                chars_accepted++;
                convert_char(chars_if.ch, chars_if.start_req, produced, fresh);
                if (produced)
                    conv_expected.push_back(fresh);
            end
            if (result_if.valid && result_if.ready)
            begin
                if (conv_expected.size() == 0)
                    report_error($sformatf("result with nothing pending, value %h",
                                           result_if.value));
                else
                begin
                    want = conv_expected.pop_front();
                    if (result_if.value !== want.value)
                        report_error($sformatf("value %h, wanted %h",
                                               result_if.value, want.value));
                    if (result_if.overflow !== want.overflow)
                        report_error($sformatf("overflow %b, wanted %b",
                                               result_if.overflow, want.overflow));
                    if (result_if.digits_found !== want.digits_found)
                        report_error($sformatf("digits_found %b, wanted %b",
                                               result_if.digits_found, want.digits_found));
                    if (result_if.end_offset !== want.end_offset)
                        report_error($sformatf("end_offset %0d, wanted %0d",
                                               result_if.end_offset, want.end_offset));
                end
            end
        end
    end

    // character driver with random gaps
    always @(negedge clk)
    begin
        char_item_t nxt;
        if (!rst_n)
            chars_if.valid <= 1'b0;
        else if (!chars_if.valid || char_taken)
        begin
            if (pending_chars.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                nxt = pending_chars.pop_front();
                chars_if.valid     <= 1'b1;
                chars_if.ch        <= nxt.ch;
                chars_if.start_req <= nxt.start_req;
            end
            else
                chars_if.valid <= 1'b0;
        end
    end

    // result stalls
    always @(negedge clk)
    begin
        result_if.ready <= rst_n && ($urandom_range(99) >= sink_idle_pct);
    end

    task automatic queue_char(input logic [CH_W-1:0] c);
        pending_chars.push_back('{ch: c, start_req: next_start});
        next_start = 1'b0;
        chars_queued++;
    endtask

    task automatic queue_text(input string s);
        foreach (s[i])
            queue_char(s[i]);
    endtask

    // everything accepted and every result in
    task automatic wait_idle();
        do
            @(negedge clk);
        while (chars_accepted != chars_queued || conv_expected.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // close any open conversion, drain, then reprogram
    task automatic apply_setting(input logic [BASE_W-1:0] b, input logic s);
        next_start = 1'b1;
        queue_char(CH_NUL);
        wait_idle();
        write_reg(CFG_BASE, b);
        write_reg(CFG_SIGNED_MODE, {5'($urandom_range(31)), s});
        gen_base = b;
    endtask

    // one well-formed conversion with random content and ending
    task automatic queue_random_conv();
        logic [VALUE_W-1:0] v;
        logic [BASE_W-1:0]  radix;
        logic [CH_W-1:0]    digs [$];
        int                 kind;
        next_start = 1'b1;
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3))
                queue_char($urandom_range(4) == 0 ? CH_SPACE
                                                  : CH_W'($urandom_range(CH_TAB, CH_CR)));
        case ($urandom_range(3))
            0: queue_char(CH_MINUS);
            1: queue_char(CH_PLUS);
            default: ;
        endcase

        // prefix and the radix the digits are written in
        radix = gen_base;
        if (gen_base == BASE_AUTO)
        begin
            case ($urandom_range(2))
                0:
                begin
                    queue_char(CH_ZERO);
                    queue_char($urandom_range(1) ? CH_LOW_X : CH_UP_X);
                    radix = BASE_HEX;
                end
                1:
                begin
                    queue_char(CH_ZERO);
                    radix = BASE_OCT;
                end
                default: radix = BASE_DEC;
            endcase
        end
        else if (gen_base == BASE_HEX && $urandom_range(1))
        begin
            queue_char(CH_ZERO);
            queue_char($urandom_range(1) ? CH_LOW_X : CH_UP_X);
        end
        if (radix < BASE_MIN || radix > MAX_BASE_DEF)
            radix = BASE_DEC;

        // mostly small values, some full width, range limits and overlong ones
        kind = $urandom_range(19);
        if (kind < 10)
            v = $urandom_range(999);
        else if (kind < 14)
            v = {$urandom, $urandom} >> $urandom_range(63);
        else if (kind < 17)
        begin
            case ($urandom_range(4))
                0: v = VAL_SMAX;
                1: v = VAL_SMIN;
                2: v = VAL_SMIN + 64'd1;
                3: v = VAL_SMAX - 64'd1;
                default: v = VAL_UMAX;
            endcase
        end
        else
            v = {$urandom, $urandom};
        do
        begin
            digs.push_front(digit_char(BASE_W'(v % VALUE_W'(radix))));
            v = v / VALUE_W'(radix);
        end
        while (v != 0);
        if (kind >= 17)
            repeat ($urandom_range(1, 3))
                digs.push_back(digit_char(BASE_W'($urandom_range(radix - 1))));
        foreach (digs[i])
            queue_char(digs[i]);

        // ending: open (next start abandons it), any byte, or a plain stop
        case ($urandom_range(9))
            0: ;
            1, 2: queue_char(CH_W'($urandom_range(255)));
            default: queue_char($urandom_range(1) ? CH_NUL
                                                  : CH_W'($urandom_range(CH_SPACE, 8'h2F)));
        endcase
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3))
                queue_char(CH_W'($urandom_range(255)));
    endtask

    // stimulus sequence
    initial
    begin
        logic [BASE_W-1:0] set_base [N_SET];
        logic              set_signed [N_SET];
        int                phase_start;
        bit                paused;
        set_base   = '{6'd10, 6'd0, 6'd16, 6'd2, 6'd36, 6'd8,
                       6'd0, 6'd1, 6'd63, 6'd16, 6'd37, 6'd10};
        set_signed = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
                       1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        chars_if.valid     = 1'b0;
        chars_if.ch        = '0;
        chars_if.start_req = 1'b0;
        result_if.ready    = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: blanks and sign, no digits, idle byte, restart under reset values
        next_start = 1'b1;
        queue_char(CH_SPACE);
        queue_char(CH_TAB);
        queue_char(8'h0A);
        queue_char(8'h0B);
        queue_char(8'h0C);
        queue_char(CH_CR);
        queue_text("+42");
        queue_char(CH_NUL);
        next_start = 1'b1;
        queue_text("-");
        queue_char(CH_NUL);
        queue_text("x");
        next_start = 1'b1;
        queue_text("12");
        next_start = 1'b1;
        queue_text("-7.");

        // directed: auto base prefixes, then a base that takes no digit
        apply_setting(BASE_AUTO, 1'b1);
        next_start = 1'b1;
        queue_text("0x1F ");
        next_start = 1'b1;
        queue_text("0Xg");
        next_start = 1'b1;
        queue_text("0179");
        apply_setting(6'd1, 1'b1);
        next_start = 1'b1;
        queue_text("5");

        // random conversions over a spread of settings
        for (int k = 0; k < N_SET; k++)
        begin
            src_idle_pct  = (k < 4) ? 19 : (k < 8) ? 69 : 0;
            sink_idle_pct = (k < 4) ? 69 : (k < 8) ? 19 : 0;
            apply_setting(set_base[k], set_signed[k]);
            phase_start = chars_queued;
            paused = 1'b0;
            while (chars_queued - phase_start < RAND_CHARS / N_SET)
            begin
                // hold the sender until the block has drained
                if (!paused && chars_queued - phase_start >= RAND_CHARS / (2 * N_SET))
                begin
                    wait_idle();
                    paused = 1'b1;
                end
                if ($urandom_range(7) == 0)
                begin
                    repeat ($urandom_range(1, 6))
                    begin
                        next_start = ($urandom_range(3) == 0);
                        queue_char(CH_W'($urandom_range(255)));
                    end
                end
                else
                    queue_random_conv();
            end
        end

        wait_idle();
        repeat (8) @(negedge clk);
        if (error_count == 0)
            $display("tb_string_to_int64_parser: PASS");
        else
            $display("tb_string_to_int64_parser: FAIL");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("tb_string_to_int64_parser: FAIL");
        $finish;
    end

endmodule

### string_to_int64_parser.f
+incdir+hw/rtl
hw/rtl/s2i_pkg.sv
hw/rtl/s2i_ifs.sv
hw/rtl/s2i_mac.sv
hw/rtl/string_to_int64_parser.sv
tb/tb_string_to_int64_parser.sv
